// ===== rtl/vfel_pkg.sv =====
// Shared types and constants for the vertex format flag to element list unit.
// Holds the step codes, the controller/datapath command and status structs
// and the element code constants. No dependencies.
`default_nettype none

package vfel_pkg;

    // Field widths
    localparam int FLAGS_W  = 21;
    localparam int STREAM_W = 8;
    localparam int OFFSET_W = 8;
    localparam int TYPE_W   = 5;
    localparam int USAGE_W  = 4;
    localparam int SLOT_W   = 3;
    localparam int ALLOC_W  = 8;

    // Texture coordinate sets and where their flags start
    localparam int UV_SETS     = 8;
    localparam int UV_BASE_BIT = 11;
    localparam int UV_CNT_W    = $clog2(UV_SETS + 1);
    localparam int CAP_W       = 5;

    // Stream codes
    localparam logic [STREAM_W-1:0] STREAM_DATA = 8'd0;
    localparam logic [STREAM_W-1:0] STREAM_END  = 8'hff;

    // Declaration data type codes
    localparam logic [TYPE_W-1:0] DT_FLOAT1 = 5'd0;
    localparam logic [TYPE_W-1:0] DT_FLOAT2 = 5'd1;
    localparam logic [TYPE_W-1:0] DT_FLOAT3 = 5'd2;
    localparam logic [TYPE_W-1:0] DT_FLOAT4 = 5'd3;
    localparam logic [TYPE_W-1:0] DT_COLOR  = 5'd4;
    localparam logic [TYPE_W-1:0] DT_UNUSED = 5'h11;

    // Usage codes
    localparam logic [USAGE_W-1:0] US_POSITION     = 4'd0;
    localparam logic [USAGE_W-1:0] US_BLENDWEIGHT  = 4'd1;
    localparam logic [USAGE_W-1:0] US_BLENDINDICES = 4'd2;
    localparam logic [USAGE_W-1:0] US_NORMAL       = 4'd3;
    localparam logic [USAGE_W-1:0] US_PSIZE        = 4'd4;
    localparam logic [USAGE_W-1:0] US_TEXCOORD     = 4'd5;
    localparam logic [USAGE_W-1:0] US_TANGENT      = 4'd6;
    localparam logic [USAGE_W-1:0] US_BINORMAL     = 4'd7;
    localparam logic [USAGE_W-1:0] US_COLOR        = 4'd10;

    // Byte advances
    localparam logic [OFFSET_W-1:0] ADV_4  = 8'd4;
    localparam logic [OFFSET_W-1:0] ADV_8  = 8'd8;
    localparam logic [OFFSET_W-1:0] ADV_12 = 8'd12;
    localparam logic [OFFSET_W-1:0] ADV_16 = 8'd16;

    // Element slot currently worked on
    typedef enum logic [3:0] {
        STEP_POS,
        STEP_WGT,
        STEP_E20,
        STEP_E40,
        STEP_E80,
        STEP_E100,
        STEP_E200,
        STEP_E400,
        STEP_UV,
        STEP_E80K,
        STEP_E100K,
        STEP_END
    } step_t;

    // Controller to datapath
    typedef struct packed {
        logic  load;   // capture a new flag word
        logic  fire;   // emit the element of the current step
        step_t step;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic present;  // current step yields an element
        logic out_free; // output register can take an element this cycle
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/vfel_dp.sv =====
// Datapath of the vertex format flag to element list unit: flag word, running
// offset, texture set counter, allocation size and the output register.
// Depends on vfel_pkg.
`default_nettype none

module vfel_dp (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire  [vfel_pkg::FLAGS_W-1:0]     format_flags,
    input  wire  vfel_pkg::cmd_t             cmd,
    output vfel_pkg::stat_t                  stat,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [vfel_pkg::STREAM_W-1:0]    stream_number,
    output logic [vfel_pkg::OFFSET_W-1:0]    byte_offset,
    output logic [vfel_pkg::TYPE_W-1:0]      element_type,
    output logic [vfel_pkg::USAGE_W-1:0]     element_usage,
    output logic [vfel_pkg::SLOT_W-1:0]      usage_slot,
    output logic                             is_last,
    output logic [vfel_pkg::ALLOC_W-1:0]     alloc_bytes
);

    logic [vfel_pkg::FLAGS_W-1:0]   flags_reg;
    logic [vfel_pkg::OFFSET_W-1:0]  off_reg, off_next;
    logic [vfel_pkg::UV_CNT_W-1:0]  uv_cnt_reg, uv_cnt_next;
    logic [vfel_pkg::UV_CNT_W-1:0]  uv_idx_reg, uv_idx_next;
    logic [vfel_pkg::ALLOC_W-1:0]   alloc_reg, alloc_next;
    logic                           out_valid_reg, out_valid_next;
    logic [vfel_pkg::STREAM_W-1:0]  stream_reg;
    logic [vfel_pkg::OFFSET_W-1:0]  offset_reg;
    logic [vfel_pkg::TYPE_W-1:0]    type_reg;
    logic [vfel_pkg::USAGE_W-1:0]   usage_reg;
    logic [vfel_pkg::SLOT_W-1:0]    slot_reg;
    logic                           last_reg;
    logic [vfel_pkg::ALLOC_W-1:0]   out_alloc_reg;

    logic [vfel_pkg::CAP_W-1:0]     cap;
    logic                           present;
    logic [vfel_pkg::STREAM_W-1:0]  el_stream;
    logic [vfel_pkg::TYPE_W-1:0]    el_type;
    logic [vfel_pkg::USAGE_W-1:0]   el_usage;
    logic [vfel_pkg::SLOT_W-1:0]    el_slot;
    logic [vfel_pkg::OFFSET_W-1:0]  el_adv;
    logic                           el_last;
    logic                           out_free;

    // Decode texture set count and allocation size of an incoming word
    always_comb
    begin
        uv_cnt_next = '0;
        for (int i = 0; i < vfel_pkg::UV_SETS; i++)
        begin
            if (format_flags[vfel_pkg::UV_BASE_BIT + i])
                uv_cnt_next = vfel_pkg::UV_CNT_W'(i + 1);
        end
        cap = vfel_pkg::CAP_W'(1) + vfel_pkg::CAP_W'(uv_cnt_next);
        if (format_flags[3])
            cap = cap + vfel_pkg::CAP_W'(4);
        else if (format_flags[2])
            cap = cap + vfel_pkg::CAP_W'(2);
        else if (format_flags[1])
            cap = cap + vfel_pkg::CAP_W'(1);
        for (int i = 5; i <= 10; i++)
            cap = cap + vfel_pkg::CAP_W'(format_flags[i]);
        cap = cap + vfel_pkg::CAP_W'(format_flags[19]) + vfel_pkg::CAP_W'(format_flags[20]);
        alloc_next = vfel_pkg::ALLOC_W'({cap + vfel_pkg::CAP_W'(1), 3'b000});
    end

    // Select the element of the current step
    always_comb
    begin
        present   = 1'b0;
        el_stream = vfel_pkg::STREAM_DATA;
        el_type   = vfel_pkg::DT_FLOAT1;
        el_usage  = vfel_pkg::US_POSITION;
        el_slot   = '0;
        el_adv    = '0;
        el_last   = 1'b0;
        case (cmd.step)
            vfel_pkg::STEP_POS:
            begin
                present = 1'b1;
                el_type = flags_reg[0] ? vfel_pkg::DT_FLOAT4 : vfel_pkg::DT_FLOAT3;
                el_adv  = flags_reg[0] ? vfel_pkg::ADV_16 : vfel_pkg::ADV_12;
            end
            vfel_pkg::STEP_WGT:
            begin
                present  = |flags_reg[3:1];
                el_usage = vfel_pkg::US_BLENDWEIGHT;
                // A single weight is one float, two or four are a float4
                el_type  = (flags_reg[3:2] == 2'b00) ? vfel_pkg::DT_FLOAT1
                                                     : vfel_pkg::DT_FLOAT4;
                el_adv   = (flags_reg[3:2] == 2'b00) ? vfel_pkg::ADV_4 : vfel_pkg::ADV_16;
            end
            vfel_pkg::STEP_E20:
            begin
                present  = flags_reg[5];
                el_type  = vfel_pkg::DT_FLOAT4;
                el_usage = vfel_pkg::US_BLENDINDICES;
                el_adv   = vfel_pkg::ADV_16;
            end
            vfel_pkg::STEP_E40:
            begin
                present  = flags_reg[6];
                el_type  = vfel_pkg::DT_FLOAT3;
                el_usage = vfel_pkg::US_NORMAL;
                el_adv   = vfel_pkg::ADV_12;
            end
            vfel_pkg::STEP_E80:
            begin
                present  = flags_reg[7];
                el_type  = vfel_pkg::DT_FLOAT1;
                el_usage = vfel_pkg::US_PSIZE;
                el_adv   = vfel_pkg::ADV_4;
            end
            vfel_pkg::STEP_E100:
            begin
                present  = flags_reg[8];
                el_type  = vfel_pkg::DT_COLOR;
                el_usage = vfel_pkg::US_COLOR;
                el_adv   = vfel_pkg::ADV_4;
            end
            vfel_pkg::STEP_E200:
            begin
                present  = flags_reg[9];
                el_type  = vfel_pkg::DT_COLOR;
                el_usage = vfel_pkg::US_COLOR;
                el_slot  = 3'd1;
                el_adv   = vfel_pkg::ADV_4;
            end
            vfel_pkg::STEP_E400:
            begin
                // Advances 16 bytes although a float3 only fills 12
                present  = flags_reg[10];
                el_type  = vfel_pkg::DT_FLOAT3;
                el_usage = vfel_pkg::US_TEXCOORD;
                el_adv   = vfel_pkg::ADV_16;
            end
            vfel_pkg::STEP_UV:
            begin
                present  = (uv_idx_reg < uv_cnt_reg);
                el_type  = vfel_pkg::DT_FLOAT2;
                el_usage = vfel_pkg::US_TEXCOORD;
                el_slot  = vfel_pkg::SLOT_W'(uv_idx_reg);
                el_adv   = vfel_pkg::ADV_8;
            end
            vfel_pkg::STEP_E80K:
            begin
                present  = flags_reg[19];
                el_type  = vfel_pkg::DT_FLOAT3;
                el_usage = vfel_pkg::US_TANGENT;
                el_adv   = vfel_pkg::ADV_12;
            end
            vfel_pkg::STEP_E100K:
            begin
                present  = flags_reg[20];
                el_type  = vfel_pkg::DT_FLOAT3;
                el_usage = vfel_pkg::US_BINORMAL;
                el_adv   = vfel_pkg::ADV_12;
            end
            default:
            begin
                present   = 1'b1;
                el_stream = vfel_pkg::STREAM_END;
                el_type   = vfel_pkg::DT_UNUSED;
                el_last   = 1'b1;
            end
        endcase
    end

    assign out_free      = !out_valid_reg || out_ready;
    assign stat.present  = present;
    assign stat.out_free = out_free;

    // Advance offset and texture index, hold the output while stalled
    always_comb
    begin
        off_next       = off_reg;
        uv_idx_next    = uv_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.load)
        begin
            off_next    = '0;
            uv_idx_next = '0;
        end
        else if (cmd.fire)
        begin
            off_next       = off_reg + el_adv;
            out_valid_next = 1'b1;
            if (cmd.step == vfel_pkg::STEP_UV)
                uv_idx_next = uv_idx_reg + vfel_pkg::UV_CNT_W'(1);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            off_reg       <= '0;
            uv_idx_reg    <= '0;
            uv_cnt_reg    <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            off_reg       <= off_next;
            uv_idx_reg    <= uv_idx_next;
            if (cmd.load)
                uv_cnt_reg <= uv_cnt_next;
        end
    end

    // Payload registers; the allocation size travels with each element so a
    // waiting end marker keeps its own size while the next word is captured
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            flags_reg <= format_flags;
            alloc_reg <= alloc_next;
        end
        if (cmd.fire)
        begin
            stream_reg    <= el_stream;
            offset_reg    <= el_last ? '0 : off_reg;
            type_reg      <= el_type;
            usage_reg     <= el_usage;
            slot_reg      <= el_slot;
            last_reg      <= el_last;
            out_alloc_reg <= alloc_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign stream_number = stream_reg;
    assign byte_offset   = offset_reg;
    assign element_type  = type_reg;
    assign element_usage = usage_reg;
    assign usage_slot    = slot_reg;
    assign is_last       = last_reg;
    assign alloc_bytes   = out_alloc_reg;

    // Texture index never runs past the decoded count
    assert property (@(posedge clk) disable iff (!rst_n) uv_idx_reg <= uv_cnt_reg)
        else $error("texture set index passed its count");

    // An element is only written into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fire |-> (!out_valid_reg || out_ready))
        else $error("element emitted over a pending result");

    // All advances are multiples of four bytes
    assert property (@(posedge clk) disable iff (!rst_n) off_reg[1:0] == 2'b00)
        else $error("running offset lost word alignment");

endmodule

`default_nettype wire

// ===== rtl/vfel_ctrl.sv =====
// Controller of the vertex format flag to element list unit: walks the fixed
// element order one slot per cycle while the output register is free, and drives the datapath commands.
// Depends on vfel_pkg.
`default_nettype none

module vfel_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire  vfel_pkg::stat_t stat,
    output vfel_pkg::cmd_t        cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS,
        ST_WGT,
        ST_E20,
        ST_E40,
        ST_E80,
        ST_E100,
        ST_E200,
        ST_E400,
        ST_UV,
        ST_E80K,
        ST_E100K,
        ST_END
    } state_t;

    state_t         state_reg, state_next;
    vfel_pkg::step_t step;

    // Map state to the datapath step
    always_comb
    begin
        case (state_reg)
            ST_POS:   step = vfel_pkg::STEP_POS;
            ST_WGT:   step = vfel_pkg::STEP_WGT;
            ST_E20:   step = vfel_pkg::STEP_E20;
            ST_E40:   step = vfel_pkg::STEP_E40;
            ST_E80:   step = vfel_pkg::STEP_E80;
            ST_E100:  step = vfel_pkg::STEP_E100;
            ST_E200:  step = vfel_pkg::STEP_E200;
            ST_E400:  step = vfel_pkg::STEP_E400;
            ST_UV:    step = vfel_pkg::STEP_UV;
            ST_E80K:  step = vfel_pkg::STEP_E80K;
            ST_E100K: step = vfel_pkg::STEP_E100K;
            default:  step = vfel_pkg::STEP_END;
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Sequence the slots; stall whenever the output register is full and not being read
    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.fire   = 1'b0;
        cmd.step   = step;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_POS;
                end
            end
            default:
            begin
                if (stat.out_free)
                begin
                    cmd.fire = stat.present;
                    case (state_reg)
                        ST_POS:   state_next = ST_WGT;
                        ST_WGT:   state_next = ST_E20;
                        ST_E20:   state_next = ST_E40;
                        ST_E40:   state_next = ST_E80;
                        ST_E80:   state_next = ST_E100;
                        ST_E100:  state_next = ST_E200;
                        ST_E200:  state_next = ST_E400;
                        ST_E400:  state_next = ST_UV;
                        // Stay until every texture set below the count is out
                        ST_UV:    state_next = stat.present ? ST_UV : ST_E80K;
                        ST_E80K:  state_next = ST_E100K;
                        ST_E100K: state_next = ST_END;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // End marker issued means the list is done
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_END && stat.out_free) |=> state_reg == ST_IDLE)
        else $error("controller did not return to idle after end marker");

    // Nothing is emitted while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !cmd.fire)
        else $error("element emitted while idle");

    // A blocked output register freezes the sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && !stat.out_free) |=> $stable(state_reg))
        else $error("controller advanced during an output stall");

endmodule

`default_nettype wire

// ===== rtl/vertex_format_flags_to_element_list_unit.sv =====
// Top level of the vertex format flag to element list unit.
// Instantiates vfel_ctrl and vfel_dp; depends on vfel_pkg.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-----------------------------------------------
//   input   | in_valid / in_ready  | format_flags
//   output  | out_valid / out_ready| stream_number, byte_offset, element_type,
//           |                      | element_usage, usage_slot, is_last, alloc_bytes
//
// With no output stalls a request runs as one capture in idle, then the slots of the fixed
// element order in turn, the texture slot looping N+1 times, N being the number of
// texture sets (0..8). The controller walks the slots one at a time and a new request
// is taken once it is back in idle.
// Reset is asynchronous, active low, and clears the sequencer and output valid.
// An output stall freezes the sequence; the last element may still wait in the
// output register while the next request is accepted.
`default_nettype none

module vertex_format_flags_to_element_list_unit (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire  [vfel_pkg::FLAGS_W-1:0]     format_flags,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [vfel_pkg::STREAM_W-1:0]    stream_number,
    output logic [vfel_pkg::OFFSET_W-1:0]    byte_offset,
    output logic [vfel_pkg::TYPE_W-1:0]      element_type,
    output logic [vfel_pkg::USAGE_W-1:0]     element_usage,
    output logic [vfel_pkg::SLOT_W-1:0]      usage_slot,
    output logic                             is_last,
    output logic [vfel_pkg::ALLOC_W-1:0]     alloc_bytes
);

    vfel_pkg::cmd_t  cmd;
    vfel_pkg::stat_t stat;

    vfel_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vfel_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .format_flags  (format_flags),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .stream_number (stream_number),
        .byte_offset   (byte_offset),
        .element_type  (element_type),
        .element_usage (element_usage),
        .usage_slot    (usage_slot),
        .is_last       (is_last),
        .alloc_bytes   (alloc_bytes)
    );

endmodule

`default_nettype wire

// ===== dv/vfel_checker.sv =====
`timescale 1ns / 100ps
// Checker for the vertex format flag to element list unit: watches both channels,
// expands each accepted flag word into its element list and compares the results.
// Depends on vfel_pkg for field widths and element codes.

module vfel_checker (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    input  wire                            in_ready,
    input  wire [vfel_pkg::FLAGS_W-1:0]    format_flags,
    input  wire                            out_valid,
    input  wire                            out_ready,
    input  wire [vfel_pkg::STREAM_W-1:0]   stream_number,
    input  wire [vfel_pkg::OFFSET_W-1:0]   byte_offset,
    input  wire [vfel_pkg::TYPE_W-1:0]     element_type,
    input  wire [vfel_pkg::USAGE_W-1:0]    element_usage,
    input  wire [vfel_pkg::SLOT_W-1:0]     usage_slot,
    input  wire                            is_last,
    input  wire [vfel_pkg::ALLOC_W-1:0]    alloc_bytes,
    output int                             fail_count,
    output int                             pending_count
);

    localparam int MAX_REPORTS = 10;

    // Flag bit positions
    localparam int FB_XYZW      = 0;
    localparam int FB_WEIGHT1   = 1;
    localparam int FB_WEIGHT2   = 2;
    localparam int FB_WEIGHT4   = 3;
    localparam int FB_INDICES   = 5;
    localparam int FB_NORMAL    = 6;
    localparam int FB_PSIZE     = 7;
    localparam int FB_DIFFUSE   = 8;
    localparam int FB_SPECULAR  = 9;
    localparam int FB_TEX_WIDE  = 10;
    localparam int FB_TANGENT   = 19;
    localparam int FB_BINORMAL  = 20;

    typedef struct packed {
        logic [vfel_pkg::STREAM_W-1:0] stream;
        logic [vfel_pkg::OFFSET_W-1:0] offset;
        logic [vfel_pkg::TYPE_W-1:0]   dtype;
        logic [vfel_pkg::USAGE_W-1:0]  usage;
        logic [vfel_pkg::SLOT_W-1:0]   slot;
        logic                          last;
        logic [vfel_pkg::ALLOC_W-1:0]  alloc;
    } element_t;

    element_t                      expected_elems[$];
    logic [vfel_pkg::OFFSET_W-1:0] run_offset;
    logic [vfel_pkg::ALLOC_W-1:0]  vertex_alloc;

    function automatic string show_element(input element_t e);
        return $sformatf("stream=%0d offset=%0d type=%0d usage=%0d slot=%0d last=%0d alloc=%0d",
                         e.stream, e.offset, e.dtype, e.usage, e.slot, e.last, e.alloc);
    endfunction

    task report_fault(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] element check: %s", $time, what);
    endtask

    // Append one data element at the running offset, then advance it
    task add_element(input logic [vfel_pkg::TYPE_W-1:0] dtype,
                     input logic [vfel_pkg::USAGE_W-1:0] usage,
                     input logic [vfel_pkg::SLOT_W-1:0] slot,
                     input logic [vfel_pkg::OFFSET_W-1:0] advance);
        element_t e;
        e.stream = vfel_pkg::STREAM_DATA;
        e.offset = run_offset;
        e.dtype  = dtype;
        e.usage  = usage;
        e.slot   = slot;
        e.last   = 1'b0;
        e.alloc  = vertex_alloc;
        expected_elems = {expected_elems, e};
        run_offset = run_offset + advance;
    endtask

    // Expand one flag word into its declaration element list
    task expand_flags(input logic [vfel_pkg::FLAGS_W-1:0] flags);
        int       tex_sets;
        int       weights;
        int       capacity;
        int       i;
        element_t marker;
        // texture set count follows the highest set texture bit
        tex_sets = 0;
        for (i = 0; i < vfel_pkg::UV_SETS; i++)
            if (flags[vfel_pkg::UV_BASE_BIT + i])
                tex_sets = i + 1;
        weights = flags[FB_WEIGHT4] ? 4 : flags[FB_WEIGHT2] ? 2 : flags[FB_WEIGHT1] ? 1 : 0;
        capacity = 1 + tex_sets + weights
                 + flags[FB_INDICES] + flags[FB_NORMAL] + flags[FB_PSIZE]
                 + flags[FB_DIFFUSE] + flags[FB_SPECULAR] + flags[FB_TEX_WIDE]
                 + flags[FB_TANGENT] + flags[FB_BINORMAL];
        vertex_alloc = vfel_pkg::ALLOC_W'((capacity + 1) * 8);
        run_offset = '0;

        if (flags[FB_XYZW])
            add_element(vfel_pkg::DT_FLOAT4, vfel_pkg::US_POSITION, '0, vfel_pkg::ADV_16);
        else
            add_element(vfel_pkg::DT_FLOAT3, vfel_pkg::US_POSITION, '0, vfel_pkg::ADV_12);
        // only one weight element whatever the weight count
        if (weights == 1)
            add_element(vfel_pkg::DT_FLOAT1, vfel_pkg::US_BLENDWEIGHT, '0, vfel_pkg::ADV_4);
        else if (weights != 0)
            add_element(vfel_pkg::DT_FLOAT4, vfel_pkg::US_BLENDWEIGHT, '0, vfel_pkg::ADV_16);
        if (flags[FB_INDICES])
            add_element(vfel_pkg::DT_FLOAT4, vfel_pkg::US_BLENDINDICES, '0, vfel_pkg::ADV_16);
        if (flags[FB_NORMAL])
            add_element(vfel_pkg::DT_FLOAT3, vfel_pkg::US_NORMAL, '0, vfel_pkg::ADV_12);
        if (flags[FB_PSIZE])
            add_element(vfel_pkg::DT_FLOAT1, vfel_pkg::US_PSIZE, '0, vfel_pkg::ADV_4);
        if (flags[FB_DIFFUSE])
            add_element(vfel_pkg::DT_COLOR, vfel_pkg::US_COLOR, '0, vfel_pkg::ADV_4);
        if (flags[FB_SPECULAR])
            add_element(vfel_pkg::DT_COLOR, vfel_pkg::US_COLOR, vfel_pkg::SLOT_W'(1),
                        vfel_pkg::ADV_4);
        // wide texcoord advances past its own size
        if (flags[FB_TEX_WIDE])
            add_element(vfel_pkg::DT_FLOAT3, vfel_pkg::US_TEXCOORD, '0, vfel_pkg::ADV_16);
        for (i = 0; i < tex_sets; i++)
            add_element(vfel_pkg::DT_FLOAT2, vfel_pkg::US_TEXCOORD, vfel_pkg::SLOT_W'(i),
                        vfel_pkg::ADV_8);
        if (flags[FB_TANGENT])
            add_element(vfel_pkg::DT_FLOAT3, vfel_pkg::US_TANGENT, '0, vfel_pkg::ADV_12);
        if (flags[FB_BINORMAL])
            add_element(vfel_pkg::DT_FLOAT3, vfel_pkg::US_BINORMAL, '0, vfel_pkg::ADV_12);

        marker.stream = vfel_pkg::STREAM_END;
        marker.offset = '0;
        marker.dtype  = vfel_pkg::DT_UNUSED;
        marker.usage  = '0;
        marker.slot   = '0;
        marker.last   = 1'b1;
        marker.alloc  = vertex_alloc;
        expected_elems = {expected_elems, marker};
    endtask

    // Predict on each accepted request, compare each accepted element
    always @(posedge clk)
    begin
        element_t got;
        element_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expand_flags(format_flags);
            if (out_valid && out_ready)
            begin
                got = '{stream_number, byte_offset, element_type, element_usage,
                        usage_slot, is_last, alloc_bytes};
                if (expected_elems.size() == 0)
                    report_fault({"unexpected element ", show_element(got)});
                else
                begin
                    want = expected_elems.pop_front();
                    if (got !== want)
                        report_fault({"mismatch\n  expected ", show_element(want),
                                      "\n  actual   ", show_element(got)});
                end
            end
        end
        pending_count <= expected_elems.size();
    end

endmodule

// ===== dv/tb_vertex_format_flags_to_element_list_unit.sv =====
`timescale 1ns / 100ps
// Testbench top for the vertex format flag to element list unit: clock, reset,
// request and ready stimulus, and the verdict. Depends on vfel_pkg, the unit
// and vfel_checker.

module tb_vertex_format_flags_to_element_list_unit;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int LONG_STALL     = 400;
    localparam int REQS_PER_PHASE = 32;
    localparam int DRAIN_CYCLES   = 40;
    localparam int NUM_DIRECTED   = 24;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          out_ready;
    logic [vfel_pkg::FLAGS_W-1:0]  format_flags;
    wire                           in_ready;
    wire                           out_valid;
    wire [vfel_pkg::STREAM_W-1:0]  stream_number;
    wire [vfel_pkg::OFFSET_W-1:0]  byte_offset;
    wire [vfel_pkg::TYPE_W-1:0]    element_type;
    wire [vfel_pkg::USAGE_W-1:0]   element_usage;
    wire [vfel_pkg::SLOT_W-1:0]    usage_slot;
    wire                           is_last;
    wire [vfel_pkg::ALLOC_W-1:0]   alloc_bytes;

    int fail_count;
    int pending_count;
    int cycle_count = 0;
    int send_idle_pct = 13;
    int recv_idle_pct = 87;
    bit hold_request = 1'b0;

    // Extremes, single flags, weight priority, sparse and full texture sets
    logic [vfel_pkg::FLAGS_W-1:0] directed_flags [NUM_DIRECTED] = '{
        21'h000000, 21'h1fffff, 21'h000001, 21'h000002, 21'h000004, 21'h000006,
        21'h00000a, 21'h000010, 21'h000020, 21'h000040, 21'h000080, 21'h000100,
        21'h000200, 21'h000400, 21'h000800, 21'h001000, 21'h040000, 21'h040800,
        21'h080000, 21'h100000, 21'h1ffffe, 21'h155555, 21'h0aaaaa, 21'h07f800
    };

    vertex_format_flags_to_element_list_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .format_flags  (format_flags),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .stream_number (stream_number),
        .byte_offset   (byte_offset),
        .element_type  (element_type),
        .element_usage (element_usage),
        .usage_slot    (usage_slot),
        .is_last       (is_last),
        .alloc_bytes   (alloc_bytes)
    );

    vfel_checker element_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .format_flags  (format_flags),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .stream_number (stream_number),
        .byte_offset   (byte_offset),
        .element_type  (element_type),
        .element_usage (element_usage),
        .usage_slot    (usage_slot),
        .is_last       (is_last),
        .alloc_bytes   (alloc_bytes),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Drive ready: random idling, or one long hold-off when requested
    initial
    begin
        int k;
        out_ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request && rst_n)
            begin
                hold_request = 1'b0;
                for (k = 0; k < LONG_STALL; k++)
                begin
                    out_ready <= 1'b0;
                    @(posedge clk);
                end
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
                @(posedge clk);
            end
        end
    end

    // Random flag word: half free, a quarter without texture sets, a quarter with a single set
    function automatic logic [vfel_pkg::FLAGS_W-1:0] random_flags();
        logic [vfel_pkg::FLAGS_W-1:0] f;
        f = vfel_pkg::FLAGS_W'($urandom);
        case ($urandom_range(3))
            2: f[vfel_pkg::UV_BASE_BIT +: vfel_pkg::UV_SETS] = '0;
            3: f[vfel_pkg::UV_BASE_BIT +: vfel_pkg::UV_SETS] =
                   vfel_pkg::UV_SETS'(1) << $urandom_range(vfel_pkg::UV_SETS - 1);
            default: ;
        endcase
        return f;
    endfunction

    // Offer one request after random idle cycles; return at its acceptance edge
    task send_request(input logic [vfel_pkg::FLAGS_W-1:0] flags);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid     <= 1'b0;
            format_flags <= vfel_pkg::FLAGS_W'($urandom);
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        format_flags <= flags;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    initial
    begin
        int i;
        int phase;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        format_flags = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < NUM_DIRECTED; i++)
            send_request(directed_flags[i]);

        // Sparse receiver, then sparse sender, then full rate with a long hold-off
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 13; recv_idle_pct = 87; end
                1: begin send_idle_pct = 87; recv_idle_pct = 13; end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_request  = 1'b1;
                end
            endcase
            for (i = 0; i < REQS_PER_PHASE; i++)
                send_request(random_flags());
        end
        in_valid <= 1'b0;
        @(posedge clk);

        // Drain outstanding elements, then watch for strays
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
